@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define PDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property, checked in every cycle including reset.
`define PDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/pdfs8_pkg.sv @@
// Types and constants for the packet deframer with 8-bit sum check.
`timescale 1ns / 1ps

package pdfs8_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [POS_W-1:0] POS_HEADER  = 9'd0;
    localparam logic [POS_W-1:0] POS_COMMAND = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH  = 9'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd3;
    localparam logic [POS_W-1:0] POS_MAX     = 9'd511;

    localparam int unsigned MIN_PACKET = 5;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h55;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_INVALID  = 2'd1,
        ERR_CHECKSUM = 2'd2
    } t_err;

    typedef struct packed {
        logic              emit;
        logic              kind;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        t_err              err;
    } t_result;

endpackage

@@ rtl/core/pdfs8_core.sv @@
// Packet framing state and per-byte result decision.
`timescale 1ns / 1ps

module pdfs8_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [pdfs8_pkg::BYTE_W-1:0]   i_byte,
    input  logic                           i_last,
    input  logic [pdfs8_pkg::BYTE_W-1:0]   i_header_byte,
    input  logic [pdfs8_pkg::BYTE_W-1:0]   i_tail_byte,
    output pdfs8_pkg::t_result             o_result
);

    localparam int unsigned PW = pdfs8_pkg::POS_W;
    localparam int unsigned BW = pdfs8_pkg::BYTE_W;
    localparam logic [PW:0] MIN_EXT   = (PW+1)'(pdfs8_pkg::MIN_PACKET);
    localparam logic [PW:0] START_EXT = {1'b0, pdfs8_pkg::POS_PAYLOAD};

    logic [PW-1:0] r_pos,      n_pos;
    logic          r_first_ok, n_first_ok;
    logic [BW-1:0] r_cmd,      n_cmd;
    logic [BW-1:0] r_len,      n_len;
    logic [BW-1:0] r_sum,      n_sum;
    logic [BW-1:0] r_prev,     n_prev;

    logic [PW:0] w_pos_ext;
    logic [PW:0] w_len_ext;

    assign w_pos_ext = {1'b0, r_pos};
    assign w_len_ext = {{(PW+1-BW){1'b0}}, r_len};

    always_comb begin
        n_pos      = r_pos;
        n_first_ok = r_first_ok;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_sum      = r_sum;
        n_prev     = r_prev;
        o_result   = '0;

        if (i_last) begin
            o_result.emit    = 1'b1;
            o_result.kind    = pdfs8_pkg::KIND_STATUS;
            o_result.command = r_cmd;
            o_result.length  = r_len;
            if ((w_pos_ext + 1'b1 < MIN_EXT) || !r_first_ok || (i_byte != i_tail_byte)) begin
                o_result.err = pdfs8_pkg::ERR_INVALID;
            end else if (w_pos_ext + 1'b1 != w_len_ext + MIN_EXT) begin
                o_result.err = pdfs8_pkg::ERR_INVALID;
            end else if (r_prev != r_sum) begin
                o_result.err = pdfs8_pkg::ERR_CHECKSUM;
            end else begin
                o_result.err = pdfs8_pkg::ERR_OK;
            end
            n_pos      = '0;
            n_first_ok = 1'b0;
            n_cmd      = '0;
            n_len      = '0;
            n_sum      = '0;
            n_prev     = '0;
        end else begin
            case (r_pos)
                pdfs8_pkg::POS_HEADER:  n_first_ok = (i_byte == i_header_byte);
                pdfs8_pkg::POS_COMMAND: n_cmd      = i_byte;
                pdfs8_pkg::POS_LENGTH:  n_len      = i_byte;
                default: ;
            endcase
            if (r_pos >= pdfs8_pkg::POS_LENGTH) begin
                n_sum = r_sum + r_prev;
            end
            n_prev = i_byte;
            if (r_pos != pdfs8_pkg::POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
            if ((r_pos >= pdfs8_pkg::POS_PAYLOAD) && (w_pos_ext < w_len_ext + START_EXT)) begin
                o_result.emit    = 1'b1;
                o_result.kind    = pdfs8_pkg::KIND_PAYLOAD;
                o_result.payload = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_first_ok <= 1'b0;
            r_cmd      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_prev     <= '0;
        end else if (i_fire) begin
            r_pos      <= n_pos;
            r_first_ok <= n_first_ok;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_prev     <= n_prev;
        end
    end

endmodule

@@ rtl/core/packet_deframer_sum8.sv @@
// Top level of the packet deframer: input register, framing core, result register.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata rx_byte, tlast end_of_packet
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata fields, tuser item_kind
//   cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the result port is not stalled; each result word
// is registered: its byte passes the input register, then the framing logic into the result register.
// Reset restores header 0xAA and tail 0x55 and clears the packet state.
// A stalled result holds in the result register; the input stalls only once both
// the result register and the input register are full.
`timescale 1ns / 1ps

module packet_deframer_sum8 (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] rx_byte
    input  logic [pdfs8_pkg::BYTE_W-1:0]           s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [7:0] payload_byte, [15:8] command_code, [23:16] payload_length,
    // [25:24] error_code, [31:26] zero
    output logic [pdfs8_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] item_kind
    output logic                                   m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pdfs8_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pdfs8_pkg::BYTE_W-1:0]           i_cfg_data
);

    localparam int unsigned BW = pdfs8_pkg::BYTE_W;
    localparam int unsigned PAD_W = pdfs8_pkg::OUT_DATA_W - 3 * BW - 2;

    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_last;

    logic          r_out_valid;
    logic          r_out_kind;
    logic [BW-1:0] r_out_payload;
    logic [BW-1:0] r_out_command;
    logic [BW-1:0] r_out_length;
    logic [1:0]    r_out_err;

    logic [BW-1:0] r_header;
    logic [BW-1:0] r_tail;

    logic               w_out_free;
    logic               w_fire;
    logic               w_in_take;
    pdfs8_pkg::t_result w_result;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= pdfs8_pkg::HEADER_RESET;
            r_tail   <= pdfs8_pkg::TAIL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pdfs8_pkg::REG_HEADER: r_header <= i_cfg_data;
                pdfs8_pkg::REG_TAIL:   r_tail   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    pdfs8_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_header_byte (r_header),
        .i_tail_byte   (r_tail),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.emit) begin
            r_out_kind    <= w_result.kind;
            r_out_payload <= w_result.payload;
            r_out_command <= w_result.command;
            r_out_length  <= w_result.length;
            r_out_err     <= w_result.err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_err, r_out_length, r_out_command,
                            r_out_payload};

endmodule

@@ rtl/core/pdfs8_checker.sv @@
// Port-level checker for the packet deframer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdfs8_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [pdfs8_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                                 m_axis_tuser
);

    `PDF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
    `PDF_ASSERT(a_payload_clean, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == pdfs8_pkg::KIND_PAYLOAD) |-> (m_axis_tdata[31:8] == 24'd0), "payload word carries status fields")
    `PDF_ASSERT(a_status_clean, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == pdfs8_pkg::KIND_STATUS) |-> (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[25:24] != 2'd3) && (m_axis_tdata[31:26] == 6'd0), "malformed status word")
    `PDF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind packet_deframer_sum8 pdfs8_checker u_pdfs8_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the packet deframer: framed bytes in, payload and status words out.
`timescale 1ns / 1ps

module testbench;

    localparam int BW           = pdfs8_pkg::BYTE_W;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic              kind;
        logic [BW-1:0]     payload;
        logic [BW-1:0]     command;
        logic [BW-1:0]     length;
        pdfs8_pkg::t_err   err;
    } t_frame_word;

    class deframe_scoreboard;
        logic [BW-1:0]                   header_cfg;
        logic [BW-1:0]                   tail_cfg;
        logic [pdfs8_pkg::POS_W-1:0]     pos;
        logic                            header_seen;
        logic [BW-1:0]                   cmd;
        logic [BW-1:0]                   len;
        logic [BW-1:0]                   sum;
        logic [BW-1:0]                   prev;
        t_frame_word                     awaited_words[$];
        int                              mismatches;

        function new();
            header_cfg = pdfs8_pkg::HEADER_RESET;
            tail_cfg   = pdfs8_pkg::TAIL_RESET;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos         = '0;
            header_seen = 1'b0;
            cmd         = '0;
            len         = '0;
            sum         = '0;
            prev        = '0;
        endfunction

        function void take_byte(logic [BW-1:0] b, logic last);
            t_frame_word w;
            int          p;
            p = int'(pos);
            w = '0;
            if (last) begin
                if (p + 1 < int'(pdfs8_pkg::MIN_PACKET) || !header_seen || b != tail_cfg)
                    w.err = pdfs8_pkg::ERR_INVALID;
                else if (p + 1 != int'(len) + int'(pdfs8_pkg::MIN_PACKET))
                    w.err = pdfs8_pkg::ERR_INVALID;
                else if (prev != sum)
                    w.err = pdfs8_pkg::ERR_CHECKSUM;
                else
                    w.err = pdfs8_pkg::ERR_OK;
                w.kind    = pdfs8_pkg::KIND_STATUS;
                w.command = cmd;
                w.length  = len;
                awaited_words.push_back(w);
                clear_frame();
                return;
            end
            if (pos == pdfs8_pkg::POS_HEADER)
                header_seen = (b == header_cfg);
            else if (pos == pdfs8_pkg::POS_COMMAND)
                cmd = b;
            else if (pos == pdfs8_pkg::POS_LENGTH)
                len = b;
            if (pos >= pdfs8_pkg::POS_LENGTH)
                sum = sum + prev;
            prev = b;
            if (pos != pdfs8_pkg::POS_MAX)
                pos = pos + 1'b1;
            if (p >= int'(pdfs8_pkg::POS_PAYLOAD) &&
                p < int'(pdfs8_pkg::POS_PAYLOAD) + int'(len)) begin
                w.kind    = pdfs8_pkg::KIND_PAYLOAD;
                w.payload = b;
                w.err     = pdfs8_pkg::ERR_OK;
                awaited_words.push_back(w);
            end
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task match_word(logic [pdfs8_pkg::OUT_DATA_W-1:0] data, logic kind);
            t_frame_word w;
            if (awaited_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word data=%h kind=%b", data, kind));
                return;
            end
            w = awaited_words.pop_front();
            if (kind !== w.kind)
                flag_mismatch($sformatf("item_kind %b, want %b", kind, w.kind));
            if (data[7:0] !== w.payload)
                flag_mismatch($sformatf("payload_byte %h, want %h", data[7:0], w.payload));
            if (data[15:8] !== w.command)
                flag_mismatch($sformatf("command_code %h, want %h", data[15:8], w.command));
            if (data[23:16] !== w.length)
                flag_mismatch($sformatf("payload_length %h, want %h", data[23:16], w.length));
            if (data[25:24] !== w.err)
                flag_mismatch($sformatf("error_code %0d, want %0d", data[25:24], w.err));
        endtask
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [BW-1:0]                         s_axis_tdata;
    logic                                  s_axis_tlast;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    logic [pdfs8_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                  m_axis_tuser;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [pdfs8_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [BW-1:0]                         i_cfg_data;

    deframe_scoreboard sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                sent_bytes;
    int                quiet_cycles;

    packet_deframer_sum8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_word(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(logic [BW-1:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_byte(b, last);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    // cut > 0 truncates the frame to at most that many bytes
    task automatic send_frame(logic [BW-1:0] hdr, logic [BW-1:0] cmd,
                              logic [BW-1:0] len, int n_payload,
                              logic [BW-1:0] sum_delta, logic [BW-1:0] tl,
                              int cut);
        logic [BW-1:0] q[$];
        logic [BW-1:0] sum;
        logic [BW-1:0] b;
        q   = '{hdr, cmd, len};
        sum = cmd + len;
        repeat (n_payload) begin
            b = BW'($urandom);
            q.push_back(b);
            sum = sum + b;
        end
        q.push_back(sum + sum_delta);
        q.push_back(tl);
        if (cut > 0)
            while (q.size() > cut) void'(q.pop_back());
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic random_frame();
        logic [BW-1:0] hdr;
        logic [BW-1:0] tl;
        logic [BW-1:0] delta;
        int            len;
        int            n;
        int            cut;
        int            pick;
        hdr   = sb.header_cfg;
        tl    = sb.tail_cfg;
        delta = '0;
        cut   = 0;
        len   = ($urandom_range(99) < 5) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        n     = len;
        pick  = $urandom_range(99);
        if (pick < 70) begin
        end else if (pick < 75) begin
            hdr = hdr ^ BW'($urandom_range(1, 255));
        end else if (pick < 80) begin
            tl = tl ^ BW'($urandom_range(1, 255));
        end else if (pick < 87) begin
            delta = BW'($urandom_range(1, 255));
        end else if (pick < 93) begin
            n = (len > 0 && $urandom_range(1) == 1) ? len - 1 : len + $urandom_range(1, 2);
        end else begin
            cut = $urandom_range(1, len + 4);
        end
        send_frame(hdr, BW'($urandom), BW'(len), n, delta, tl, cut);
    endtask

    task automatic random_frames(int budget);
        int start;
        start = sent_bytes;
        while (sent_bytes - start < budget) random_frame();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [pdfs8_pkg::CFG_IDX_W-1:0] idx, logic [BW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == pdfs8_pkg::REG_HEADER)
            sb.header_cfg = val;
        else
            sb.tail_cfg = val;
        @(negedge i_clk);
    endtask

    task automatic set_phase(logic [BW-1:0] hdr, logic [BW-1:0] tl,
                             int send_pct, int recv_pct);
        write_reg(pdfs8_pkg::REG_HEADER, hdr);
        write_reg(pdfs8_pkg::REG_TAIL, tl);
        i_cfg_valid    <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_bytes     = 0;
        quiet_cycles   = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = pdfs8_pkg::REG_HEADER;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_frame(pdfs8_pkg::HEADER_RESET, 8'h00, 8'd0, 0, 8'h00, pdfs8_pkg::TAIL_RESET, 0);
        send_frame(pdfs8_pkg::HEADER_RESET, 8'hFF, 8'd2, 2, 8'h00, pdfs8_pkg::TAIL_RESET, 0);
        send_frame(pdfs8_pkg::HEADER_RESET, 8'h10, 8'd1, 1, 8'h01, pdfs8_pkg::TAIL_RESET, 0);
        send_frame(pdfs8_pkg::HEADER_RESET, 8'h01, 8'd3, 3, 8'h00, pdfs8_pkg::TAIL_RESET, 5);
        send_frame(pdfs8_pkg::HEADER_RESET, 8'h00, 8'd0, 0, 8'h00, pdfs8_pkg::TAIL_RESET, 1);
        random_frames(30);
        drain_results();

        set_phase(8'h00, 8'hFF, 73, 0);
        send_frame(sb.header_cfg, 8'h7E, 8'd255, 255, 8'h00, sb.tail_cfg, 0);
        random_frames(20);
        drain_results();

        set_phase(8'hFF, 8'h00, 0, 73);
        send_frame(sb.header_cfg, 8'h81, 8'd255, 515, 8'h00, sb.tail_cfg, 0);
        random_frames(30);
        drain_results();

        set_phase(BW'($urandom), BW'($urandom), 35, 35);
        random_frames(15);
        drain_results();
        random_frames(15);
        drain_results();

        set_phase(8'h5A, 8'hA5, 0, 0);
        random_frames(20);
        drain_results();

        if (sb.awaited_words.size() != 0)
            sb.flag_mismatch($sformatf("%0d words never arrived", sb.awaited_words.size()));
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pdfs8_pkg.sv
rtl/core/pdfs8_core.sv
rtl/core/packet_deframer_sum8.sv
rtl/core/pdfs8_checker.sv
sim/testbench.sv
